// File: design/dwindle_tile_splitter_assert.svh
// assertion macros for the dwindle tile splitter
`ifndef DWINDLE_TILE_SPLITTER_ASSERT_SVH
`define DWINDLE_TILE_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define DTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked on every edge, reset included
`define DTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/dts_pkg.sv
// shared constants and types of the dwindle tile splitter
`default_nettype none
package dts_pkg;

  localparam int FIELD_W = 16;
  // extent of any rectangle fits here, it comes from 16-bit work area edges
  localparam int USABLE_W = 16;

  localparam int OUTER_GAP  = 10;
  localparam int INNER_GAP  = 8;
  localparam int MIN_TILE_W = 80;
  localparam int MIN_TILE_H = 70;

  // floor(u*56/100) == (u * 56 * ceil(2^29/100)) >> 29, exact for u < 2^16
  localparam int RATIO_SHIFT = 29;
  localparam int RATIO_W     = 29;
  localparam logic [RATIO_W-1:0] RATIO_MUL = 29'd300647760;

  typedef logic        [FIELD_W-1:0] win_id_t;
  typedef logic signed [FIELD_W-1:0] area_t;

  typedef enum logic [1:0] {
    CFG_AREA_LEFT   = 2'd0,
    CFG_AREA_TOP    = 2'd1,
    CFG_AREA_RIGHT  = 2'd2,
    CFG_AREA_BOTTOM = 2'd3
  } cfg_reg_t;

  localparam area_t AREA_LEFT_RST   = 16'sd0;
  localparam area_t AREA_TOP_RST    = 16'sd0;
  localparam area_t AREA_RIGHT_RST  = 16'sd1920;
  localparam area_t AREA_BOTTOM_RST = 16'sd1080;

endpackage
`default_nettype wire

// File: design/dwindle_tile_splitter.sv
// top level of the dwindle tile splitter
//
//   channel | direction | handshake            | payload
//   in      | request   | in_valid / in_stall  | window id, last-of-set flag
//   out     | result    | out_valid / out_stall| window id, tile edges
//   cfg     | write     | cfg_valid / cfg_ready| register index, data
//
// one item per cycle unless out stalls; a request passes the input then the result register
// the rate is set by the remaining-rectangle feedback through one split per cycle
// rst_n is synchronous; it clears the pipeline and the set state, area gets its defaults
// out_stall holds the result register; the input register still takes one more request
// area writes take effect on the next request that starts a set
`default_nettype none
`include "dwindle_tile_splitter_assert.svh"
module dwindle_tile_splitter #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dts_pkg::win_id_t    in_window_id,
  input  wire logic                in_is_final,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dts_pkg::win_id_t         out_window_out_id,
  output dts_pkg::area_t           out_tile_left,
  output dts_pkg::area_t           out_tile_top,
  output dts_pkg::area_t           out_tile_right,
  output dts_pkg::area_t           out_tile_bottom,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire dts_pkg::area_t      cfg_data
);

  localparam int CB = COORD_BITS;

  // work area and its inset start rectangle
  dts_pkg::area_t area_left_r, area_top_r, area_right_r, area_bottom_r;
  dts_pkg::area_t area_left_nxt, area_top_nxt, area_right_nxt, area_bottom_nxt;
  logic signed [CB-1:0] ins_left, ins_top, ins_right, ins_bottom;
  logic                 ins_across;
  logic signed [CB-1:0] st_left_r, st_top_r, st_right_r, st_bottom_r;
  logic                 st_across_r;

  // input and result registers
  logic             a_valid_r, a_final_r;
  dts_pkg::win_id_t a_id_r;
  logic             out_valid_r;
  logic             accept, advance;

  // set state
  logic signed [CB-1:0] rem_left_r, rem_top_r, rem_right_r, rem_bottom_r;
  logic signed [CB-1:0] rem_left_nxt, rem_top_nxt, rem_right_nxt, rem_bottom_nxt;
  logic                 across_r, across_nxt, busy_r, busy_nxt;

  logic signed [CB-1:0] cur_left, cur_top, cur_right, cur_bottom;
  logic                 cur_across;
  logic signed [CB-1:0] sp_lo, sp_hi, sp_cut, sp_next;
  logic signed [CB-1:0] res_right, res_bottom;

  assign cfg_ready = 1'b1;

  always_comb begin
    area_left_nxt   = area_left_r;
    area_top_nxt    = area_top_r;
    area_right_nxt  = area_right_r;
    area_bottom_nxt = area_bottom_r;
    if (!rst_n) begin
      area_left_nxt   = dts_pkg::AREA_LEFT_RST;
      area_top_nxt    = dts_pkg::AREA_TOP_RST;
      area_right_nxt  = dts_pkg::AREA_RIGHT_RST;
      area_bottom_nxt = dts_pkg::AREA_BOTTOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dts_pkg::cfg_reg_t'(cfg_index))
        dts_pkg::CFG_AREA_LEFT:   area_left_nxt   = cfg_data;
        dts_pkg::CFG_AREA_TOP:    area_top_nxt    = cfg_data;
        dts_pkg::CFG_AREA_RIGHT:  area_right_nxt  = cfg_data;
        dts_pkg::CFG_AREA_BOTTOM: area_bottom_nxt = cfg_data;
      endcase
    end
  end

  // inset follows the area at the same edge as the write
  dts_inset #(.CB(CB)) u_inset (
    .area_left    (area_left_nxt),
    .area_top     (area_top_nxt),
    .area_right   (area_right_nxt),
    .area_bottom  (area_bottom_nxt),
    .rect_left    (ins_left),
    .rect_top     (ins_top),
    .rect_right   (ins_right),
    .rect_bottom  (ins_bottom),
    .across_width (ins_across)
  );

  always_ff @(posedge clk) begin
    area_left_r   <= area_left_nxt;
    area_top_r    <= area_top_nxt;
    area_right_r  <= area_right_nxt;
    area_bottom_r <= area_bottom_nxt;
    st_left_r     <= ins_left;
    st_top_r      <= ins_top;
    st_right_r    <= ins_right;
    st_bottom_r   <= ins_bottom;
    st_across_r   <= ins_across;
  end

  assign advance  = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cur_left   = busy_r ? rem_left_r   : st_left_r;
    cur_top    = busy_r ? rem_top_r    : st_top_r;
    cur_right  = busy_r ? rem_right_r  : st_right_r;
    cur_bottom = busy_r ? rem_bottom_r : st_bottom_r;
    cur_across = busy_r ? across_r     : st_across_r;
    sp_lo = cur_across ? cur_left  : cur_top;
    sp_hi = cur_across ? cur_right : cur_bottom;
  end

  dts_split #(.CB(CB)) u_split (
    .lo           (sp_lo),
    .hi           (sp_hi),
    .across_width (cur_across),
    .cut          (sp_cut),
    .next         (sp_next)
  );

  always_comb begin
    res_right  = cur_right;
    res_bottom = cur_bottom;
    if (!a_final_r) begin
      if (cur_across) res_right  = sp_cut;
      else            res_bottom = sp_cut;
    end
    if (res_right < cur_left)  res_right  = cur_left;
    if (res_bottom < cur_top)  res_bottom = cur_top;

    rem_left_nxt   = rem_left_r;
    rem_top_nxt    = rem_top_r;
    rem_right_nxt  = rem_right_r;
    rem_bottom_nxt = rem_bottom_r;
    across_nxt     = across_r;
    busy_nxt       = busy_r;
    if (advance) begin
      if (a_final_r) begin
        busy_nxt = 1'b0;
      end else begin
        rem_left_nxt   = cur_across ? sp_next : cur_left;
        rem_top_nxt    = cur_across ? cur_top : sp_next;
        rem_right_nxt  = cur_right;
        rem_bottom_nxt = cur_bottom;
        across_nxt     = !cur_across;
        busy_nxt       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      busy_r       <= 1'b0;
      across_r     <= 1'b0;
      rem_left_r   <= '0;
      rem_top_r    <= '0;
      rem_right_r  <= '0;
      rem_bottom_r <= '0;
    end else begin
      a_valid_r    <= accept || (a_valid_r && !advance);
      out_valid_r  <= advance || (out_valid_r && out_stall);
      busy_r       <= busy_nxt;
      across_r     <= across_nxt;
      rem_left_r   <= rem_left_nxt;
      rem_top_r    <= rem_top_nxt;
      rem_right_r  <= rem_right_nxt;
      rem_bottom_r <= rem_bottom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_id_r    <= in_window_id;
      a_final_r <= in_is_final;
    end
    if (advance) begin
      out_window_out_id <= a_id_r;
      out_tile_left     <= dts_pkg::FIELD_W'(cur_left);
      out_tile_top      <= dts_pkg::FIELD_W'(cur_top);
      out_tile_right    <= dts_pkg::FIELD_W'(res_right);
      out_tile_bottom   <= dts_pkg::FIELD_W'(res_bottom);
    end
  end

  assign out_valid = out_valid_r;

  `DTS_ASSERT(a_split_opens_set, clk, rst_n, advance && !a_final_r |=> busy_r, "split request did not keep a set open")
  `DTS_ASSERT(a_last_closes_set, clk, rst_n, advance && a_final_r |=> !busy_r, "last request did not close the set")
  `DTS_ASSERT(a_stall_needs_item, clk, rst_n, !in_stall || a_valid_r, "input stalled with empty input register")
  `DTS_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !a_valid_r && !out_valid_r, "reset left a request")
  `DTS_ASSERT(a_tile_ordered, clk, rst_n, out_valid_r |-> (out_tile_right >= out_tile_left) && (out_tile_bottom >= out_tile_top), "tile edges inverted")

endmodule
`default_nettype wire

// File: design/dts_inset.sv
// work area inset by the outer gap, plus first split direction
`default_nettype none
module dts_inset #(
  parameter int CB = 16
) (
  input  wire dts_pkg::area_t     area_left,
  input  wire dts_pkg::area_t     area_top,
  input  wire dts_pkg::area_t     area_right,
  input  wire dts_pkg::area_t     area_bottom,
  output logic signed [CB-1:0]    rect_left,
  output logic signed [CB-1:0]    rect_top,
  output logic signed [CB-1:0]    rect_right,
  output logic signed [CB-1:0]    rect_bottom,
  output logic                    across_width
);

  localparam int IW = ((CB > dts_pkg::FIELD_W) ? CB : dts_pkg::FIELD_W) + 2;
  localparam logic signed [IW-1:0] SAT_HI = {{(IW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [IW-1:0] SAT_LO = {{(IW-CB+1){1'b1}}, {(CB-1){1'b0}}};
  localparam logic signed [IW-1:0] GAP    = IW'(dts_pkg::OUTER_GAP);

  function automatic logic signed [CB-1:0] sat(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] c;
    priority if (v > SAT_HI) c = SAT_HI;
    else if (v < SAT_LO)     c = SAT_LO;
    else                     c = v;
    return CB'(c);
  endfunction

  logic signed [CB-1:0] right_raw, bottom_raw;
  logic signed [CB:0]   width_ext, height_ext;

  always_comb begin
    rect_left   = sat(IW'(area_left) + GAP);
    rect_top    = sat(IW'(area_top) + GAP);
    right_raw   = sat(IW'(area_right) - GAP);
    bottom_raw  = sat(IW'(area_bottom) - GAP);
    // an inverted inset collapses onto its near edge
    rect_right  = (right_raw < rect_left) ? rect_left : right_raw;
    rect_bottom = (bottom_raw < rect_top) ? rect_top : bottom_raw;
    width_ext   = (CB+1)'(rect_right) - (CB+1)'(rect_left);
    height_ext  = (CB+1)'(rect_bottom) - (CB+1)'(rect_top);
    across_width = (width_ext >= height_ext);
  end

endmodule
`default_nettype wire

// File: design/dts_split.sv
// one split of the remaining rectangle along the chosen axis
`default_nettype none
module dts_split #(
  parameter int CB = 16
) (
  input  wire logic signed [CB-1:0] lo,
  input  wire logic signed [CB-1:0] hi,
  input  wire logic                 across_width,
  output logic signed [CB-1:0]      cut,
  output logic signed [CB-1:0]      next
);

  localparam int UW = dts_pkg::USABLE_W;
  localparam int WW = ((CB > UW + 1) ? CB : UW + 1) + 2;
  localparam int PW = UW + dts_pkg::RATIO_W;
  localparam logic signed [WW-1:0] SAT_HI = {{(WW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [WW-1:0] SAT_LO = {{(WW-CB+1){1'b1}}, {(CB-1){1'b0}}};

  function automatic logic signed [CB-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] c;
    priority if (v > SAT_HI) c = SAT_HI;
    else if (v < SAT_LO)     c = SAT_LO;
    else                     c = v;
    return CB'(c);
  endfunction

  logic signed [CB:0]   total, usable_s;
  logic [UW-1:0]        usable, quarter, min_tile, minsz, ratio_part, part_lo;
  logic [PW-1:0]        prod;
  logic signed [UW:0]   upper, part;
  logic signed [CB-1:0] cut_sat;

  always_comb begin
    total    = (CB+1)'(hi) - (CB+1)'(lo);
    usable_s = total - (CB+1)'(dts_pkg::INNER_GAP);
    usable   = (usable_s > 0) ? UW'(usable_s) : UW'(1);
    quarter  = usable >> 2;
    min_tile = across_width ? UW'(dts_pkg::MIN_TILE_W) : UW'(dts_pkg::MIN_TILE_H);
    minsz    = (quarter > min_tile) ? quarter : min_tile;
    prod       = PW'(usable) * PW'(dts_pkg::RATIO_MUL);
    ratio_part = prod[dts_pkg::RATIO_SHIFT +: UW];
    part_lo    = (ratio_part < minsz) ? minsz : ratio_part;
    // the upper bound wins and may go negative
    upper = signed'({1'b0, usable}) - signed'({1'b0, minsz});
    part  = (signed'({1'b0, part_lo}) > upper) ? upper : signed'({1'b0, part_lo});
    cut_sat = sat(WW'(lo) + WW'(part));
    if (total <= 1) begin
      cut  = hi;
      next = lo;
    end else begin
      cut  = cut_sat;
      next = sat(WW'(cut_sat) + WW'(dts_pkg::INNER_GAP));
    end
  end

endmodule
`default_nettype wire
